// ----- rtl/core/wsd_pkg.sv -----
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

    localparam int DEFAULT_LENGTH_WIDTH = 64;

    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [2:0] KEY_BYTES   = 3'd4;

    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       fin_flag;
        logic [2:0] reserved_bits;
        logic [3:0] frame_opcode;
        logic       empty_frame;
        logic       last_of_frame;
    } result_t;

endpackage

// ----- rtl/core/wsd_if.sv -----
// Valid/ready channel interfaces for the input byte stream and the result words.
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       fin_flag;
    logic [2:0] reserved_bits;
    logic [3:0] frame_opcode;
    logic       empty_frame;
    logic       last_of_frame;

    modport source (output valid, output payload_byte, output fin_flag,
                    output reserved_bits, output frame_opcode,
                    output empty_frame, output last_of_frame, input ready);
    modport sink   (input valid, input payload_byte, input fin_flag,
                    input reserved_bits, input frame_opcode,
                    input empty_frame, input last_of_frame, output ready);
endinterface

// ----- rtl/core/wsd_out_skid.sv -----
// Two-entry output register with skid stage for result words.
module wsd_out_skid
    import wsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg, main_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!main_valid_reg || pop)
        begin
            main_valid_next = push;
            main_data_next  = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- rtl/core/websocket_frame_deframer.sv -----
// WebSocket frame deframer top level: byte-wise header parse and payload unmasking.
// Throughput: one byte accepted per cycle, sustained, while results are taken.
// Result words are registered in the output buffer before they become visible.
// A two-word output buffer keeps bytes flowing while one result waits downstream.
// Reset (rst_n low, asynchronous) returns to expecting a first header byte, state zero.
module websocket_frame_deframer
    import wsd_pkg::*;
#(
    parameter int LENGTH_WIDTH = DEFAULT_LENGTH_WIDTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    wsd_in_if.sink   stream,
    wsd_out_if.source result
);

    phase_t                  phase_reg, phase_next;
    logic                    fin_reg, fin_next;
    logic [2:0]              rsv_reg, rsv_next;
    logic [3:0]              opc_reg, opc_next;
    logic                    masked_reg, masked_next;
    logic [LENGTH_WIDTH-1:0] len_reg, len_next;
    logic [3:0]              len_left_reg, len_left_next;
    logic [31:0]             key_reg, key_next;
    logic [2:0]              key_left_reg, key_left_next;
    logic [1:0]              key_idx_reg, key_idx_next;

    logic                    accept;
    logic                    space;
    logic                    push;
    result_t                 res;
    result_t                 out_data;
    logic [7:0]              b;
    logic [6:0]              len7;
    logic [LENGTH_WIDTH-1:0] ext_len;
    logic [3:0]              len_left_dec;
    logic [2:0]              key_left_dec;
    logic [7:0]              key_byte;

    assign b            = stream.in_byte;
    assign len7         = b[6:0];
    assign accept       = stream.valid && space;
    assign stream.ready = space;
    assign ext_len      = {len_reg[LENGTH_WIDTH-9:0], b};
    assign len_left_dec = len_left_reg - 4'd1;
    assign key_left_dec = key_left_reg - 3'd1;

    always_comb
    begin
        case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR2:
                begin
                    if (len7 == LEN_EXT16 || len7 == LEN_EXT64)
                        phase_next = PH_EXTLEN;
                    else if (b[7])
                        phase_next = PH_KEY;
                    else if (len7 == 7'd0)
                        phase_next = PH_HDR1;
                    else
                        phase_next = PH_PAYLOAD;
                end
                PH_EXTLEN:
                begin
                    if (len_left_dec == 4'd0)
                    begin
                        if (masked_reg)
                            phase_next = PH_KEY;
                        else if (ext_len == '0)
                            phase_next = PH_HDR1;
                        else
                            phase_next = PH_PAYLOAD;
                    end
                end
                PH_KEY:
                begin
                    if (key_left_dec == 3'd0)
                        phase_next = (len_reg == '0) ? PH_HDR1 : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (len_reg == LENGTH_WIDTH'(1))
                        phase_next = PH_HDR1;
                end
                default:
                    phase_next = PH_HDR2;
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        fin_next      = fin_reg;
        rsv_next      = rsv_reg;
        opc_next      = opc_reg;
        masked_next   = masked_reg;
        len_next      = len_reg;
        len_left_next = len_left_reg;
        key_next      = key_reg;
        key_left_next = key_left_reg;
        key_idx_next  = key_idx_reg;
        push          = 1'b0;
        res.payload_byte  = 8'd0;
        res.fin_flag      = fin_reg;
        res.reserved_bits = rsv_reg;
        res.frame_opcode  = opc_reg;
        res.empty_frame   = 1'b1;
        res.last_of_frame = 1'b1;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR2:
                begin
                    masked_next = b[7];
                    if (len7 == LEN_EXT16)
                    begin
                        len_left_next = EXT16_BYTES;
                        len_next      = '0;
                    end
                    else if (len7 == LEN_EXT64)
                    begin
                        len_left_next = EXT64_BYTES;
                        len_next      = '0;
                    end
                    else
                    begin
                        len_left_next = 4'd0;
                        len_next      = LENGTH_WIDTH'(len7);
                        if (b[7])
                            key_left_next = KEY_BYTES;
                        else if (len7 == 7'd0)
                            push = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    len_next      = ext_len;
                    len_left_next = len_left_dec;
                    if (len_left_dec == 4'd0)
                    begin
                        if (masked_reg)
                            key_left_next = KEY_BYTES;
                        else if (ext_len == '0)
                            push = 1'b1;
                    end
                end
                PH_KEY:
                begin
                    key_next      = {key_reg[23:0], b};
                    key_left_next = key_left_dec;
                    if (key_left_dec == 3'd0 && len_reg == '0)
                        push = 1'b1;
                end
                PH_PAYLOAD:
                begin
                    // len_reg counts the payload bytes still to come, this one included
                    key_idx_next      = key_idx_reg + 2'd1;
                    len_next          = len_reg - LENGTH_WIDTH'(1);
                    push              = 1'b1;
                    res.payload_byte  = masked_reg ? (b ^ key_byte) : b;
                    res.empty_frame   = 1'b0;
                    res.last_of_frame = (len_reg == LENGTH_WIDTH'(1));
                end
                default:
                begin
                    fin_next      = b[7];
                    rsv_next      = b[6:4];
                    opc_next      = b[3:0];
                    masked_next   = 1'b0;
                    len_next      = '0;
                    len_left_next = 4'd0;
                    key_next      = 32'd0;
                    key_left_next = 3'd0;
                    key_idx_next  = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR1;
            fin_reg      <= 1'b0;
            rsv_reg      <= 3'd0;
            opc_reg      <= 4'd0;
            masked_reg   <= 1'b0;
            len_reg      <= '0;
            len_left_reg <= 4'd0;
            key_reg      <= 32'd0;
            key_left_reg <= 3'd0;
            key_idx_reg  <= 2'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            fin_reg      <= fin_next;
            rsv_reg      <= rsv_next;
            opc_reg      <= opc_next;
            masked_reg   <= masked_next;
            len_reg      <= len_next;
            len_left_reg <= len_left_next;
            key_reg      <= key_next;
            key_left_reg <= key_left_next;
            key_idx_reg  <= key_idx_next;
        end
    end

    wsd_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .space     (space),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_data)
    );

    assign result.payload_byte  = out_data.payload_byte;
    assign result.fin_flag      = out_data.fin_flag;
    assign result.reserved_bits = out_data.reserved_bits;
    assign result.frame_opcode  = out_data.frame_opcode;
    assign result.empty_frame   = out_data.empty_frame;
    assign result.last_of_frame = out_data.last_of_frame;

    a_payload_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_PAYLOAD) |-> push)
        else $error("payload byte accepted without a result word");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res.empty_frame) |-> (res.last_of_frame && res.payload_byte == 8'd0))
        else $error("empty-frame word not marked last or carries data");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res.last_of_frame) |=> (phase_reg == PH_HDR1))
        else $error("frame end did not return to header phase");

    a_payload_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (len_reg != '0))
        else $error("payload phase with no bytes remaining");

endmodule
